FILE: rtl/pmrle_pkg.sv
// shared types and constants of the mixed run-length row decoder
package pmrle_pkg;

   // field widths
   localparam int unsigned DIM_CFG_W = 13;
   localparam int unsigned COL_W     = 17;
   localparam int unsigned ROW_W     = 13;
   localparam int unsigned FIELD_W   = 12;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned VALUE_W   = 24;

   // stream control bytes
   localparam logic [7:0] CTRL_LONG_RUN = 8'h80;
   localparam logic [7:0] RUN_BIAS      = 8'h7F;

   // alpha remap
   localparam logic [7:0] ALPHA_FULL     = 8'hFF;
   localparam logic [7:0] ALPHA_FULL_MAP = 8'h80;

   // register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_HAS_ALPHA    = 2'd2;

   // register reset values
   localparam logic [DIM_CFG_W-1:0] WIDTH_RESET  = 13'd256;
   localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 13'd256;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       image_start;
   } req_type;

   typedef struct packed {
      logic               plane;
      logic [FIELD_W-1:0] row;
      logic [FIELD_W-1:0] column;
      logic [LEN_W-1:0]   run_length;
      logic [VALUE_W-1:0] pixel_value;
      logic               image_end;
   } rsp_type;

   typedef struct packed {
      logic [DIM_CFG_W-1:0] image_width;
      logic [DIM_CFG_W-1:0] image_height;
      logic                 has_alpha;
   } cfg_type;

   typedef struct packed {
      logic emit;
      logic done;
   } core_status_type;

endpackage

FILE: rtl/pmrle_core.sv
// byte phase machine, run counters and segment builder
module pmrle_core import pmrle_pkg::*; #(
   parameter int unsigned MAX_DIM = 4096
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            step,
   input  req_type         item,
   output core_status_type status,
   output rsp_type         result
);

   localparam logic [2:0] PH_CTRL   = 3'd0;
   localparam logic [2:0] PH_CNT_HI = 3'd1;
   localparam logic [2:0] PH_CNT_LO = 3'd2;
   localparam logic [2:0] PH_V0     = 3'd3;
   localparam logic [2:0] PH_V1     = 3'd4;
   localparam logic [2:0] PH_V2     = 3'd5;

   localparam logic [COL_W-1:0] DIM_LIMIT = COL_W'(MAX_DIM);
   localparam logic [COL_W-1:0] COL_SAT   = {COL_W{1'b1}};

   // zero acts as one, above the limit acts as the limit
   function automatic logic [COL_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
      logic [COL_W-1:0] wide;
      wide = {{(COL_W-DIM_CFG_W){1'b0}}, v};
      if (v == '0) begin
         return COL_W'(1);
      end else if (wide > DIM_LIMIT) begin
         return DIM_LIMIT;
      end
      return wide;
   endfunction

   function automatic logic [7:0] remap_alpha(input logic [7:0] a);
      if (a == ALPHA_FULL) begin
         return ALPHA_FULL_MAP;
      end else if (a == 8'd0) begin
         return 8'd0;
      end else if (a == 8'd1) begin
         return 8'd1;
      end
      return {1'b0, a[7:1]};
   endfunction

   logic [2:0]         phase_ff, phase_in;
   logic               plane_ff, plane_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [LEN_W-1:0]   run_ff, run_in;
   logic [VALUE_W-1:0] accum_ff, accum_in;
   logic [7:0]         lit_ff, lit_in;
   logic               done_ff, done_in;

   // state as seen by this byte, after an image start clears it
   logic [2:0]         cur_phase;
   logic               cur_plane;
   logic [COL_W-1:0]   cur_col;
   logic [ROW_W-1:0]   cur_row;
   logic [LEN_W-1:0]   cur_run;
   logic [VALUE_W-1:0] cur_accum;
   logic [7:0]         cur_lit;
   logic               cur_done;

   assign cur_phase = item.image_start ? PH_CTRL : phase_ff;
   assign cur_plane = item.image_start ? 1'b0 : plane_ff;
   assign cur_col   = item.image_start ? '0 : col_ff;
   assign cur_row   = item.image_start ? '0 : row_ff;
   assign cur_run   = item.image_start ? '0 : run_ff;
   assign cur_accum = item.image_start ? '0 : accum_ff;
   assign cur_lit   = item.image_start ? '0 : lit_ff;
   assign cur_done  = item.image_start ? 1'b0 : done_ff;

   logic [7:0]       b;
   logic             finish;
   logic [LEN_W-1:0] len;
   logic [COL_W:0]   col_sum;
   logic             emit;

   assign b = item.code_byte;

   // byte decode, then segment build when a value is complete
   always_comb begin
      phase_in = cur_phase;
      plane_in = cur_plane;
      col_in   = cur_col;
      row_in   = cur_row;
      run_in   = cur_run;
      accum_in = cur_accum;
      lit_in   = cur_lit;
      done_in  = cur_done;
      finish   = 1'b0;
      emit     = 1'b0;
      len      = '0;
      col_sum  = '0;
      result   = '0;

      if (!cur_done) begin
         case (cur_phase)
            PH_CTRL: begin
               accum_in = '0;
               if (b == CTRL_LONG_RUN) begin
                  phase_in = PH_CNT_HI;
               end else if (b > CTRL_LONG_RUN) begin
                  run_in   = {8'd0, b - RUN_BIAS};
                  lit_in   = '0;
                  phase_in = PH_V0;
               end else begin
                  lit_in   = b + 8'd1;
                  run_in   = '0;
                  phase_in = PH_V0;
               end
            end
            PH_CNT_HI: begin
               run_in   = {b, 8'd0};
               phase_in = PH_CNT_LO;
            end
            PH_CNT_LO: begin
               run_in   = cur_run | {8'd0, b};
               lit_in   = '0;
               phase_in = PH_V0;
            end
            PH_V0: begin
               if (cur_plane) begin
                  accum_in = {16'd0, remap_alpha(b)};
                  finish   = 1'b1;
               end else begin
                  accum_in = {b, 16'd0};
                  phase_in = PH_V1;
               end
            end
            PH_V1: begin
               accum_in = cur_accum | {8'd0, b, 8'd0};
               phase_in = PH_V2;
            end
            PH_V2: begin
               accum_in = cur_accum | {16'd0, b};
               finish   = 1'b1;
            end
            default: begin
               phase_in = PH_CTRL;
            end
         endcase
      end

      // value complete: one literal pixel or a whole run
      if (finish) begin
         if (cur_lit != 8'd0) begin
            len      = LEN_W'(1);
            lit_in   = cur_lit - 8'd1;
            phase_in = (lit_in != 8'd0) ? PH_V0 : PH_CTRL;
         end else begin
            len      = cur_run;
            phase_in = PH_CTRL;
         end

         if (len != '0) begin
            emit    = 1'b1;
            col_sum = {1'b0, cur_col} + {{(COL_W+1-LEN_W){1'b0}}, len};
            col_in  = col_sum[COL_W] ? COL_SAT : col_sum[COL_W-1:0];

            result.plane       = cur_plane;
            result.row         = (|cur_row[ROW_W-1:FIELD_W]) ? {FIELD_W{1'b1}}
                                                             : cur_row[FIELD_W-1:0];
            result.column      = (|cur_col[COL_W-1:FIELD_W]) ? {FIELD_W{1'b1}}
                                                             : cur_col[FIELD_W-1:0];
            result.run_length  = len;
            result.pixel_value = accum_in;

            // row end after the last pixel of a group
            if (phase_in == PH_CTRL && col_in >= clamp_dim(cfg.image_width)) begin
               col_in = '0;
               if (!cur_plane && cfg.has_alpha) begin
                  plane_in = 1'b1;
               end else begin
                  plane_in = 1'b0;
                  row_in   = cur_row + ROW_W'(1);
                  if ({{(COL_W-ROW_W){1'b0}}, row_in} >= clamp_dim(cfg.image_height)) begin
                     done_in          = 1'b1;
                     result.image_end = 1'b1;
                  end
               end
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CTRL;
         plane_ff <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
         run_ff   <= '0;
         accum_ff <= '0;
         lit_ff   <= '0;
         done_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         plane_ff <= plane_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         run_ff   <= run_in;
         accum_ff <= accum_in;
         lit_ff   <= lit_in;
         done_ff  <= done_in;
      end
   end

   assign status.emit = emit;
   assign status.done = done_ff;

endmodule

FILE: rtl/pic_mixed_rle_row_decoder.sv
// top level: input register, decoder core, result register, control registers
//
//  port group  direction  handshake           payload
//  req_        in         req_valid/req_stall req_data   (code byte, image start)
//  rsp_        out        rsp_valid/rsp_stall rsp_data   (one run segment)
//  csr_        in         csr_we              csr_index, csr_wdata
//
// one byte per cycle unless the result stalls; a byte waits in the input
// register and its segment, if any, enters the result register as the
// byte leaves. the phase machine and counters form their next state
// combinationally, so bytes may follow back to back. reset clears state
// and loads register defaults. a stalled result holds back the input byte.
module pic_mixed_rle_row_decoder import pmrle_pkg::*; #(
   parameter int unsigned MAX_DIM = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [DIM_CFG_W-1:0] csr_wdata
);

   cfg_type         cfg_ff;
   logic            in_valid_ff, in_valid_in;
   req_type         in_item_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_item_ff;
   logic            out_free;
   logic            step;
   logic            req_accept;
   core_status_type status;
   rsp_type         result;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= WIDTH_RESET;
         cfg_ff.image_height <= HEIGHT_RESET;
         cfg_ff.has_alpha    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata;
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata;
            CSR_HAS_ALPHA:    cfg_ff.has_alpha    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // flow control
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign step       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !step);
   assign out_valid_in = (step && status.emit) || (out_valid_ff && rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_item_ff <= req_data;
      end
   end

   pmrle_core #(
      .MAX_DIM (MAX_DIM)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .step   (step),
      .item   (in_item_ff),
      .status (status),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step && status.emit) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   // zero-length runs never reach the output
   a_no_empty_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.run_length != '0)
      else $error("segment with zero run length");

   // alpha segments carry only the low value byte
   a_alpha_narrow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.plane) |-> rsp_data.pixel_value[VALUE_W-1:8] == '0)
      else $error("alpha segment with upper value bits set");

   // the final segment closes the image
   a_end_sets_done: assert property (@(posedge clock) disable iff (reset)
      (step && status.emit && result.image_end) |=> status.done)
      else $error("image end without done state");

   // a segment is only built when the result register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !step)
      else $error("result register overwritten while stalled");

endmodule
